FILE: rtl/smb_pkg.sv
// shared types and constants of the serial loaded bank mapper
package smb_pkg;

    // default bank limits of the cartridge
    localparam int MAX_PRG_BANKS_DEF = 32;
    localparam int MAX_CHR_BANKS_DEF = 32;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int OFFSET_W = 19;
    localparam int MIRROR_W = 2;

    // configuration register indexes
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    // where an access goes
    typedef enum logic [2:0] {
        TGT_UNMAPPED = 3'd0,
        TGT_PATTERN  = 3'd1,
        TGT_RAM      = 3'd2,
        TGT_PROGRAM  = 3'd3,
        TGT_REGISTER = 3'd4
    } target_t;

    // one classified request waiting for the back end
    typedef struct packed {
        target_t               target;
        logic                  operation;
        logic [ADDR_W-1:0]     address;
        logic [DATA_W-1:0]     data;
    } entry_t;

    // one translated request
    typedef struct packed {
        target_t               target;
        logic [OFFSET_W-1:0]   mem_offset;
        logic                  mem_write;
        logic [DATA_W-1:0]     write_data;
        logic [MIRROR_W-1:0]   mirroring;
    } result_t;

endpackage

FILE: rtl/smb_front.sv
// front end: takes requests and classifies them by address window
module smb_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_operation,
    input  logic [smb_pkg::ADDR_W-1:0]   in_address,
    input  logic [smb_pkg::DATA_W-1:0]   in_data,
    output logic                         push,
    output smb_pkg::entry_t              push_entry,
    input  logic                         full
);

    // address bits 15..13 of the fixed windows
    localparam logic [2:0] PATTERN_AREA = 3'b000;
    localparam logic [2:0] RAM_AREA     = 3'b011;

    logic            valid_reg;
    smb_pkg::entry_t entry_reg;
    smb_pkg::entry_t entry_next;
    logic            take;

    assign push       = valid_reg && !full;
    assign push_entry = entry_reg;
    assign in_ready   = !valid_reg || !full;
    assign take       = in_valid && in_ready;

    always_comb
    begin
        entry_next.operation = in_operation;
        entry_next.address   = in_address;
        entry_next.data      = in_data;
        if (in_address[15])
        begin
            entry_next.target = in_operation ? smb_pkg::TGT_REGISTER
                                             : smb_pkg::TGT_PROGRAM;
        end
        else if (in_address[15:13] == PATTERN_AREA)
        begin
            entry_next.target = smb_pkg::TGT_PATTERN;
        end
        else if (in_address[15:13] == RAM_AREA)
        begin
            entry_next.target = smb_pkg::TGT_RAM;
        end
        else
        begin
            entry_next.target = smb_pkg::TGT_UNMAPPED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: rtl/smb_queue.sv
// short request queue between front and back
module smb_queue
#(
    parameter int DEPTH = smb_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  smb_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output smb_pkg::entry_t pop_entry,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    smb_pkg::entry_t   slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + AW'(1);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> (count_reg == CW'(DEPTH)))
        else $error("queue lost an entry while full");

endmodule

FILE: rtl/smb_back.sv
// back end: serial loader, bank registers, window offsets and result register
module smb_back
#(
    parameter int MAX_PRG_BANKS = smb_pkg::MAX_PRG_BANKS_DEF,
    parameter int MAX_CHR_BANKS = smb_pkg::MAX_CHR_BANKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [smb_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          empty,
    input  smb_pkg::entry_t               pop_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smb_pkg::result_t              out_result
);

    localparam int CW = smb_pkg::COUNT_W;
    localparam logic [4:0]    LOADER_EMPTY = 5'h10;
    localparam logic [4:0]    CTRL_RESET_OR = 5'h0C;
    localparam logic [CW-1:0] COUNT_RESET  = CW'(2);

    // register select from address bits 14..13
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PROGRAM  = 2'd3;

    // program modes from control bits 3..2
    localparam logic [1:0] PMODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PMODE_FIX_LAST  = 2'd3;

    logic [4:0]    shift_reg,     shift_next;
    logic [4:0]    ctrl_reg,      ctrl_next;
    logic [4:0]    chr_lo_reg,    chr_lo_next;
    logic [4:0]    chr_hi_reg,    chr_hi_next;
    logic [3:0]    rom_bank_reg,  rom_bank_next;
    logic [CW-1:0] prg_count_reg, prg_count_next;
    logic [CW-1:0] chr_count_reg, chr_count_next;
    logic          loaded_reg,    loaded_next;
    logic          stale_reg,     stale_next;
    logic          out_valid_reg;

    logic [18:0]   prg_off_reg [2];
    logic [16:0]   chr_off_reg [2];
    logic [18:0]   prg_off_next [2];
    logic [16:0]   chr_off_next [2];

    smb_pkg::result_t out_reg, out_next;

    logic          take;
    logic [4:0]    shifted;
    logic [CW-1:0] pc;
    logic [CW-1:0] cc;
    logic [4:0]    pb0, pb1, cb0, cb1;
    logic [4:0]    prg_last;

    // bank count limited to 1..max
    function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] n,
                                                  input logic [CW-1:0] maxv);
        logic [CW-1:0] r;
        if (n == '0)
        begin
            r = CW'(1);
        end
        else if (n > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = n;
        end
        return r;
    endfunction

    // five-bit restoring remainder, one dividend bit a step
    function automatic logic [4:0] bank_mod(input logic [4:0] idx,
                                            input logic [CW-1:0] cnt);
        logic [CW-1:0] rem;
        rem = '0;
        for (int i = 4; i >= 0; i--)
        begin
            rem = {rem[CW-2:0], idx[i]};
            if (rem >= cnt)
            begin
                rem = rem - cnt;
            end
        end
        return rem[4:0];
    endfunction

    assign take      = !empty && !stale_reg && (!out_valid_reg || out_ready);
    assign pop       = take;
    assign out_valid = out_valid_reg;
    assign out_result = out_reg;
    assign shifted   = {pop_entry.data[0], shift_reg[4:1]};

    // window offsets are registered and follow the bank registers in the next cycle
    always_comb
    begin
        pc = clamp_count(prg_count_reg, CW'(MAX_PRG_BANKS));
        cc = clamp_count(chr_count_reg, CW'(MAX_CHR_BANKS));
        prg_last = 5'(pc - CW'(1));
        pb0 = '0;
        pb1 = prg_last;
        cb0 = '0;
        cb1 = '0;
        if (loaded_reg)
        begin
            case (ctrl_reg[3:2])
                PMODE_FIX_FIRST:
                begin
                    pb0 = '0;
                    pb1 = bank_mod({1'b0, rom_bank_reg}, pc);
                end
                PMODE_FIX_LAST:
                begin
                    pb0 = bank_mod({1'b0, rom_bank_reg}, pc);
                    pb1 = prg_last;
                end
                default:
                begin
                    pb0 = bank_mod({1'b0, rom_bank_reg[3:1], 1'b0}, pc);
                    pb1 = bank_mod({1'b0, rom_bank_reg[3:1], 1'b1}, pc);
                end
            endcase
            if (ctrl_reg[4])
            begin
                cb0 = bank_mod(chr_lo_reg, cc);
                cb1 = bank_mod(chr_hi_reg, cc);
            end
            else
            begin
                cb0 = bank_mod({chr_lo_reg[4:1], 1'b0}, cc);
                cb1 = bank_mod({chr_lo_reg[4:1], 1'b1}, cc);
            end
        end
        prg_off_next[0] = {pb0, 14'b0};
        prg_off_next[1] = {pb1, 14'b0};
        chr_off_next[0] = {cb0, 12'b0};
        chr_off_next[1] = {cb1, 12'b0};
    end

    // loader, bank registers and counts
    always_comb
    begin
        shift_next     = shift_reg;
        ctrl_next      = ctrl_reg;
        chr_lo_next    = chr_lo_reg;
        chr_hi_next    = chr_hi_reg;
        rom_bank_next  = rom_bank_reg;
        prg_count_next = prg_count_reg;
        chr_count_next = chr_count_reg;
        loaded_next    = loaded_reg;
        stale_next     = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                smb_pkg::CFG_PRG_COUNT: prg_count_next = cfg_data;
                smb_pkg::CFG_CHR_COUNT: chr_count_next = cfg_data;
                default: ;
            endcase
            stale_next = 1'b1;
        end
        if (take && pop_entry.target == smb_pkg::TGT_REGISTER)
        begin
            if (pop_entry.data[7])
            begin
                shift_next  = LOADER_EMPTY;
                ctrl_next   = ctrl_reg | CTRL_RESET_OR;
                loaded_next = 1'b1;
                stale_next  = 1'b1;
            end
            else if (shift_reg[0])
            begin
                case (pop_entry.address[14:13])
                    SEL_CONTROL:  ctrl_next     = shifted;
                    SEL_CHR_LOW:  chr_lo_next   = shifted;
                    SEL_CHR_HIGH: chr_hi_next   = shifted;
                    SEL_PROGRAM:  rom_bank_next = shifted[3:0];
                    default: ;
                endcase
                shift_next  = LOADER_EMPTY;
                loaded_next = 1'b1;
                stale_next  = 1'b1;
            end
            else
            begin
                shift_next = shifted;
            end
        end
    end

    // translated result
    always_comb
    begin
        out_next.target     = pop_entry.target;
        out_next.mem_offset = '0;
        out_next.mem_write  = 1'b0;
        out_next.write_data = '0;
        out_next.mirroring  = ctrl_next[1:0];
        case (pop_entry.target)
            smb_pkg::TGT_PATTERN:
            begin
                out_next.mem_offset = 19'(chr_off_reg[pop_entry.address[12]])
                                    + 19'(pop_entry.address[11:0]);
                out_next.mem_write  = pop_entry.operation;
            end
            smb_pkg::TGT_RAM:
            begin
                out_next.mem_offset = 19'(pop_entry.address[12:0]);
                out_next.mem_write  = pop_entry.operation;
            end
            smb_pkg::TGT_PROGRAM:
            begin
                out_next.mem_offset = prg_off_reg[pop_entry.address[14]]
                                    + 19'(pop_entry.address[13:0]);
            end
            default: ;
        endcase
        if (out_next.mem_write)
        begin
            out_next.write_data = pop_entry.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= LOADER_EMPTY;
            ctrl_reg      <= '0;
            chr_lo_reg    <= '0;
            chr_hi_reg    <= '0;
            rom_bank_reg  <= '0;
            prg_count_reg <= COUNT_RESET;
            chr_count_reg <= COUNT_RESET;
            loaded_reg    <= 1'b0;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            ctrl_reg      <= ctrl_next;
            chr_lo_reg    <= chr_lo_next;
            chr_hi_reg    <= chr_hi_next;
            rom_bank_reg  <= rom_bank_next;
            prg_count_reg <= prg_count_next;
            chr_count_reg <= chr_count_next;
            loaded_reg    <= loaded_next;
            stale_reg     <= stale_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prg_off_reg[0] <= prg_off_next[0];
        prg_off_reg[1] <= prg_off_next[1];
        chr_off_reg[0] <= chr_off_next[0];
        chr_off_reg[1] <= chr_off_next[1];
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    a_marker_kept: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg != '0)
        else $error("serial loader lost its marker bit");

    a_bubble_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pop_entry.target == smb_pkg::TGT_REGISTER
              && (pop_entry.data[7] || shift_reg[0])) |=> !take)
        else $error("request issued with stale window offsets");

    a_write_targets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.mem_write) |->
            (out_reg.target == smb_pkg::TGT_PATTERN
             || out_reg.target == smb_pkg::TGT_RAM))
        else $error("memory write outside pattern memory or ram");

endmodule

FILE: rtl/serial_loaded_bank_mapper.sv
// top level of the serial loaded bank mapper
// Translates one bus request at a time into a target memory and byte offset.
// Pattern memory (below 0x2000) is reached through two 4 KB windows, battery
// ram sits at 0x6000..0x7FFF, and program reads at 0x8000 and above go through
// two 16 KB windows. Writes at 0x8000 and above feed a five-bit serial loader;
// the fifth bit lands in control, pattern bank 0, pattern bank 1 or program
// bank depending on address bits 14..13, and data bit 7 resets the loader.
// A front stage classifies each request and hands it through a two-entry
// queue to the back end, which keeps the bank registers and drives a
// registered result. When nothing stalls, a taken request passes through the
// front entry register, a queue slot and the result register before m_tvalid
// rises, and one request per cycle is sustained.
// Each completed register load, loader reset or configuration write holds
// the back end while the window offsets are recomputed by the bank modulo
// logic (a five-step remainder per window). Bank counts of 0 act as 1 and
// counts above the maximum act as the maximum.
module serial_loaded_bank_mapper
#(
    parameter int MAX_PRG_BANKS = smb_pkg::MAX_PRG_BANKS_DEF,
    parameter int MAX_CHR_BANKS = smb_pkg::MAX_CHR_BANKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [smb_pkg::COUNT_W-1:0]   cfg_data,
    // request side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // address[15:0], data[23:16]
    input  logic                          s_tuser,   // operation
    // result side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // mem_offset[18:0], mem_write[19],
                                                     // write_data[27:20], mirroring[29:28]
    output logic [2:0]                    m_tuser    // target
);

    smb_pkg::entry_t  push_entry;
    smb_pkg::entry_t  pop_entry;
    smb_pkg::result_t result;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    // classify the incoming request
    smb_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_operation (s_tuser),
        .in_address   (s_tdata[15:0]),
        .in_data      (s_tdata[23:16]),
        .push         (push),
        .push_entry   (push_entry),
        .full         (full)
    );

    // decouples classification from the register side
    smb_queue #(
        .DEPTH (smb_pkg::QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    // loader, banks, window offsets and result register
    smb_back #(
        .MAX_PRG_BANKS (MAX_PRG_BANKS),
        .MAX_CHR_BANKS (MAX_CHR_BANKS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .empty      (empty),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result, unused high bits zero
    assign m_tuser = result.target;
    assign m_tdata = {2'b00, result.mirroring, result.write_data,
                      result.mem_write, result.mem_offset};

endmodule
